// ===== hdl/eml_pkg.sv =====
// shared types and constants for the metadata list parser
`timescale 1ns / 1ps

package eml_pkg;

  localparam logic [7:0] END_MARK    = 8'h7f;
  localparam logic [2:0] STRING_TYPE = 3'd4;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_LEN_LO  = 3'd1,
    ROLE_LEN_HI  = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_TERM    = 3'd4,
    ROLE_IGNORED = 3'd5
  } role_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // payload length per entry type; the string type carries its own length
  function automatic logic [15:0] fixed_size(input logic [2:0] etype);
    logic [15:0] size;
    case (etype)
      3'd0:    size = 16'd1;
      3'd1:    size = 16'd2;
      3'd2:    size = 16'd4;
      3'd3:    size = 16'd4;
      3'd5:    size = 16'd5;
      3'd6:    size = 16'd12;
      3'd7:    size = 16'd8;
      default: size = 16'd0;
    endcase
    return size;
  endfunction

endpackage

// ===== hdl/entity_metadata_list_parser.sv =====
// metadata list parser: classifies each byte of a tagged metadata list
// Usage:
//   in_*  : one list byte per item; in_tuser marks the first byte of a new
//           list (parser restarts there), in_tlast marks the packet's last byte.
//   out_* : one result per input item, in order. out_tdata holds the byte
//           role and the entry type, out_tlast is high on the terminator
//           byte, out_tuser is high when the packet ended before the
//           terminator.
// Pipeline: each item passes through the input register, then the result
// register; a low out_tready can hold an item in the input register.
// Throughput: one item per cycle while out_tready is high; the parse state
// (phase, remaining payload count, length low byte, entry type) is updated
// once per item, with at most one decrement of the remaining count.
// Reset: rst_n low clears both pipeline valids and puts the parser in the
// expect-header phase.
// Stall: when out_tready is low the result holds; the input register still
// takes one more item, after which in_tready drops until the result drains.
`timescale 1ns / 1ps

module entity_metadata_list_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // start_list
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] byte_role, [5:3] entry_type, [7:6] zero
  output logic       out_tlast,  // list_done
  output logic       out_tuser   // truncated
);

  // input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_last_r;

  // parse state
  eml_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     left_r, left_nxt;
  logic [7:0]      len_lo_r, len_lo_nxt;
  logic [2:0]      type_r, type_nxt;

  // result register
  logic            out_v_r;
  eml_pkg::role_t  role_r, role_nxt;
  logic [2:0]      etype_r, etype_nxt;
  logic            done_r, done_nxt;
  logic            trunc_r, trunc_nxt;

  logic            s1_adv;
  logic            was_done;
  eml_pkg::phase_t ph_base;
  logic [15:0]     left_base;
  logic [7:0]      len_lo_base;
  logic [2:0]      type_base;
  logic [15:0]     str_len;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  always_comb begin
    // a start byte restarts the parser before it is classified
    ph_base     = s1_start_r ? eml_pkg::PH_HEADER : phase_r;
    left_base   = s1_start_r ? 16'd0 : left_r;
    len_lo_base = s1_start_r ? 8'd0 : len_lo_r;
    type_base   = s1_start_r ? 3'd0 : type_r;
    str_len     = {s1_byte_r, len_lo_base};

    phase_nxt  = ph_base;
    left_nxt   = left_base;
    len_lo_nxt = len_lo_base;
    type_nxt   = type_base;
    role_nxt   = eml_pkg::ROLE_IGNORED;
    etype_nxt  = 3'd0;
    done_nxt   = 1'b0;
    was_done   = 1'b0;

    case (ph_base)
      eml_pkg::PH_HEADER: begin
        if (s1_byte_r == eml_pkg::END_MARK) begin
          role_nxt  = eml_pkg::ROLE_TERM;
          done_nxt  = 1'b1;
          phase_nxt = eml_pkg::PH_DONE;
        end else begin
          type_nxt  = s1_byte_r[7:5];
          role_nxt  = eml_pkg::ROLE_HEADER;
          etype_nxt = s1_byte_r[7:5];
          if (s1_byte_r[7:5] == eml_pkg::STRING_TYPE) begin
            phase_nxt = eml_pkg::PH_LEN_LO;
          end else begin
            left_nxt  = eml_pkg::fixed_size(s1_byte_r[7:5]);
            phase_nxt = eml_pkg::PH_PAYLOAD;
          end
        end
      end
      eml_pkg::PH_LEN_LO: begin
        len_lo_nxt = s1_byte_r;
        role_nxt   = eml_pkg::ROLE_LEN_LO;
        etype_nxt  = type_base;
        phase_nxt  = eml_pkg::PH_LEN_HI;
      end
      eml_pkg::PH_LEN_HI: begin
        role_nxt  = eml_pkg::ROLE_LEN_HI;
        etype_nxt = type_base;
        // empty string goes straight back to the next header
        if (str_len == 16'd0) begin
          phase_nxt = eml_pkg::PH_HEADER;
        end else begin
          left_nxt  = str_len;
          phase_nxt = eml_pkg::PH_PAYLOAD;
        end
      end
      eml_pkg::PH_PAYLOAD: begin
        role_nxt  = eml_pkg::ROLE_PAYLOAD;
        etype_nxt = type_base;
        if (left_base <= 16'd1) begin
          left_nxt  = 16'd0;
          phase_nxt = eml_pkg::PH_HEADER;
        end else begin
          left_nxt = left_base - 16'd1;
        end
      end
      default: begin
        was_done = 1'b1;
      end
    endcase

    trunc_nxt = s1_last_r && !was_done && (phase_nxt != eml_pkg::PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= eml_pkg::PH_HEADER;
      left_r   <= 16'd0;
      len_lo_r <= 8'd0;
      type_r   <= 3'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r  <= 1'b1;
        phase_r  <= phase_nxt;
        left_r   <= left_nxt;
        len_lo_r <= len_lo_nxt;
        type_r   <= type_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
    if (s1_adv) begin
      role_r  <= role_nxt;
      etype_r <= etype_nxt;
      done_r  <= done_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, etype_r, role_r};
  assign out_tlast  = done_r;
  assign out_tuser  = trunc_r;

endmodule

// ===== hdl/eml_checker.sv =====
// port-level assertions for the metadata list parser, bound to the top level
`timescale 1ns / 1ps

module eml_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // terminator item: type zero, never truncated
  a_term_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[2:0] == eml_pkg::ROLE_TERM && out_tdata[5:3] == 3'd0 && !out_tuser)
    else $error("terminator item has bad fields");

  // the terminator role always carries list_done
  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == eml_pkg::ROLE_TERM |-> out_tlast)
    else $error("terminator role without list_done");

  // ignored bytes carry no type and no flags
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == eml_pkg::ROLE_IGNORED |->
      out_tdata[5:3] == 3'd0 && !out_tlast && !out_tuser)
    else $error("ignored item has flags set");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind entity_metadata_list_parser eml_checker u_eml_checker (.*);
